### src/gmr_pkg.sv
`default_nettype none

package gmr_pkg;

  // Model dimensions.
  localparam int MAX_COMPONENTS = 8;
  localparam int OUT_DIMS       = 3;
  localparam int SHOWN_DIMS     = (OUT_DIMS < 3) ? OUT_DIMS : 3;
  localparam int RES_N          = 3;

  // Model store layout: one row of sixteen words per component.
  localparam int SLOT_W    = 4;
  localparam int SLOT_SPAN = 16;
  localparam int CIDX_W    = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int RAM_DEPTH = MAX_COMPONENTS * SLOT_SPAN;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);
  localparam int CNT_W     = $clog2(MAX_COMPONENTS + 1);
  localparam int DIM_W     = (SHOWN_DIMS > 1) ? $clog2(SHOWN_DIMS) : 1;

  localparam logic [SLOT_W-1:0] SLOT_WEIGHT = 4'd0;
  localparam logic [SLOT_W-1:0] SLOT_MEAN   = 4'd1;
  localparam logic [SLOT_W-1:0] SLOT_VAR    = 4'd2;
  localparam int SLOT_OMEAN = 3;
  localparam int SLOT_COV   = 3 + OUT_DIMS;
  localparam int SLOT_END   = 3 + 2 * OUT_DIMS;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Fixed-point constants in Q16.16.
  localparam logic [18:0] TWO_PI_Q16 = 19'd411775;
  localparam logic [16:0] LOG2E_Q16  = 17'd94548;

  // Shared long divider and square-root unit sizes.
  localparam int DIV_NW     = 96;
  localparam int DIV_DW     = 64;
  localparam int DIV_CNT_W  = $clog2(DIV_NW);
  localparam int SQ_OUT_W   = 25;
  localparam int SQ_IN_W    = 2 * SQ_OUT_W;
  localparam int SQ_CNT_W   = $clog2(SQ_OUT_W);

  typedef struct packed {
    logic        mode;
    logic [2:0]  component;
    logic [3:0]  slot;
    logic [31:0] word_value;
    logic [31:0] query_time;
  } gmr_in_t;

  typedef struct packed {
    logic [31:0] time_echo;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;
    logic        no_support;
  } gmr_out_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_FETCH_W, ST_FETCH_MU, ST_FETCH_VAR, ST_CAP_VAR, ST_PREP,
    ST_SQUARE, ST_DIVQ, ST_WAITQ, ST_LOG, ST_EXP, ST_SHIFT, ST_DIVP,
    ST_WAITP, ST_BETA, ST_CHKB, ST_RD_MEAN, ST_RD_COV, ST_CAP_COV, ST_MULC,
    ST_DIVC, ST_WAITC, ST_MSUM, ST_ACC_LO, ST_ACC_HI, ST_ACC_ADD, ST_NEXT,
    ST_FIN, ST_FIN_DIV, ST_FIN_WAIT, ST_FIN_SAT, ST_DONE
  } gmr_state_t;

  typedef logic [15:0][31:0] pow_tab_t;

  // Floor square root, evaluated at elaboration only.
  function automatic logic [63:0] isqrt_const(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    logic [63:0] rem;
    res  = '0;
    rem  = x;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Table of 2^(-2^(b-16)) in Q0.32 for the fractional exponent bits.
  function automatic pow_tab_t build_pow_tab();
    logic [63:0] t;
    pow_tab_t    tab;
    int          b;
    t = isqrt_const(64'h8000_0000_0000_0000);
    tab[15] = t[31:0];
    for (b = 15; b > 0; b--) begin
      t = isqrt_const({t[31:0], 32'h0});
      tab[b-1] = t[31:0];
    end
    return tab;
  endfunction

  localparam pow_tab_t POW_TAB = build_pow_tab();

endpackage

`default_nettype wire

### src/gaussian_mixture_regression_unit.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall   gmr_in_t (load word or query time)
// out_      output     out_valid / out_stall gmr_out_t (one item per query)
// cfg_      input      cfg_we               cfg_data (active component count)
//
// A load item writes the model store directly.
// A query runs the full computation for each component with non-zero support,
// skips each other one early, and ends with the final averages; the shared
// one-bit-per-cycle long divider sets nearly all of the query's duration.
// Reset is synchronous and active low; the model store holds no reset value.
// A finished item waits in the output register while the next item is taken.

module gaussian_mixture_regression_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire gmr_pkg::gmr_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output gmr_pkg::gmr_out_t      out_data,
  input  wire logic              cfg_we,
  input  wire logic [3:0]        cfg_data
);

  import gmr_pkg::*;

  gmr_state_t state_r, state_nxt;

  logic [3:0]       act_r;
  logic             out_valid_r;
  gmr_out_t         out_data_r;
  logic             in_accept;
  logic             q_accept;
  logic             load_out;
  logic [CNT_W-1:0] n_new;

  // Model store.
  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr;
  logic [RAM_AW-1:0] ram_raddr;
  logic [31:0]       rd_data;
  logic [SLOT_W-1:0] rd_slot;

  // Shared arithmetic units.
  logic              div_start;
  logic [DIV_NW-1:0] div_dd;
  logic [DIV_DW-1:0] div_dv;
  logic              div_busy;
  logic [DIV_NW-1:0] div_quo;
  logic              sq_start;
  logic              sq_busy;
  logic [SQ_OUT_W-1:0] sq_root;

  // Per-query and per-component datapath registers.
  logic [31:0]      t_r;
  logic [CNT_W-1:0] n_r;
  logic [CNT_W-1:0] k_r;
  logic [CNT_W-1:0] k_inc;
  logic [DIM_W-1:0] j_r;
  logic [31:0]      w_r;
  logic [31:0]      mu_r;
  logic [31:0]      var_r;
  logic             d_neg_r;
  logic [32:0]      ad_r;
  logic [65:0]      prod_r;
  logic [SQ_IN_W-1:0] sq_in_r;
  logic [37:0]      y_r;
  logic [3:0]       b_r;
  logic             one_r;
  logic [31:0]      r_r;
  logic [32:0]      e_r;
  logic [61:0]      wp_r;
  logic [53:0]      beta_r;
  logic [56:0]      den_r;
  logic [31:0]      mean_r;
  logic [31:0]      cov_r;
  logic [64:0]      cprod_r;
  logic             mneg_r;
  logic [31:0]      m_r;
  logic [58:0]      plo_r;
  logic [58:0]      phi_r;
  logic [89:0]      acc_r [SHOWN_DIMS];
  logic [31:0]      res_r [RES_N];

  // Combinational helpers.
  logic [32:0]        d_full;
  logic [15:0]        frac;
  logic [63:0]        rmul;
  logic [31:0]        acov;
  logic [33:0]        qmc;
  logic signed [35:0] msum;
  logic [31:0]        mmag;
  logic [89:0]        term;
  logic [89:0]        accmag;
  logic [31:0]        qc;
  logic [31:0]        qsat;

  assign in_accept = in_valid && !in_stall;
  assign q_accept  = in_accept && in_data.mode == MODE_QUERY;
  assign in_stall  = (state_r != ST_IDLE);
  assign load_out  = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  assign n_new     = (32'(act_r) > MAX_COMPONENTS) ? CNT_W'(MAX_COMPONENTS) : CNT_W'(act_r);
  assign k_inc     = k_r + CNT_W'(1);

  // Loads write only while idle and queries only read, so no access can
  // overlap a write to the same entry.
  assign ram_we    = in_accept && in_data.mode == MODE_LOAD
                     && 32'(in_data.component) < MAX_COMPONENTS
                     && 32'(in_data.slot) < SLOT_END;
  assign ram_waddr = {CIDX_W'(in_data.component), in_data.slot};
  assign ram_raddr = {k_r[CIDX_W-1:0], rd_slot};

  gmr_ram #(
    .WIDTH (32),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data.word_value),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  gmr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dd),
    .divisor  (div_dv),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  gmr_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_in_r),
    .busy     (sq_busy),
    .root     (sq_root)
  );

  // Arithmetic that sits between the datapath registers.
  always_comb begin
    d_full = {t_r[31], t_r} - {mu_r[31], mu_r};
    frac   = y_r[31:16];
    rmul   = 64'(r_r) * 64'(POW_TAB[b_r]);
    acov   = cov_r[31] ? (32'd0 - cov_r) : cov_r;
    qmc    = (div_quo > 96'h2_0000_0000) ? 34'h2_0000_0000 : div_quo[33:0];
    msum   = $signed({{4{mean_r[31]}}, mean_r})
             + (mneg_r ? -$signed({2'b00, qmc}) : $signed({2'b00, qmc}));
    mmag   = m_r[31] ? (32'd0 - m_r) : m_r;
    term   = (90'(phi_r) << 27) + 90'(plo_r);
    accmag = acc_r[j_r][89] ? (90'd0 - acc_r[j_r]) : acc_r[j_r];
    qc     = (div_quo > 96'h8000_0000) ? 32'h8000_0000 : div_quo[31:0];
    if (!acc_r[j_r][89] && qc > 32'h7FFF_FFFF) begin
      qsat = 32'h7FFF_FFFF;
    end else begin
      qsat = acc_r[j_r][89] ? (32'd0 - qc) : qc;
    end
  end

  // Sequencer: next state, store reads and unit starts.
  always_comb begin
    state_nxt = state_r;
    rd_slot   = SLOT_WEIGHT;
    div_start = 1'b0;
    div_dd    = '0;
    div_dv    = '0;
    sq_start  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_accept) begin
          state_nxt = (n_new == '0) ? ST_FIN : ST_FETCH_W;
        end
      end
      ST_FETCH_W: begin
        rd_slot   = SLOT_WEIGHT;
        state_nxt = ST_FETCH_MU;
      end
      ST_FETCH_MU: begin
        rd_slot   = SLOT_MEAN;
        state_nxt = ST_FETCH_VAR;
      end
      ST_FETCH_VAR: begin
        rd_slot   = SLOT_VAR;
        state_nxt = ST_CAP_VAR;
      end
      ST_CAP_VAR: state_nxt = ST_PREP;
      ST_PREP: begin
        if (!w_r[31] && w_r != '0 && !var_r[31] && var_r != '0) begin
          state_nxt = ST_SQUARE;
        end else begin
          state_nxt = ST_NEXT;
        end
      end
      ST_SQUARE: state_nxt = ST_DIVQ;
      ST_DIVQ: begin
        div_start = 1'b1;
        div_dd    = DIV_NW'(prod_r);
        div_dv    = DIV_DW'(var_r);
        sq_start  = 1'b1;
        state_nxt = ST_WAITQ;
      end
      ST_WAITQ: begin
        if (!div_busy && !sq_busy) begin
          state_nxt = ST_LOG;
        end
      end
      ST_LOG: begin
        // The exponential underflows to zero once h reaches 32.
        state_nxt = (div_quo[DIV_NW-1:22] != '0) ? ST_NEXT : ST_EXP;
      end
      ST_EXP: begin
        if (b_r == 4'd0) begin
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: state_nxt = ST_DIVP;
      ST_DIVP: begin
        div_start = 1'b1;
        div_dd    = DIV_NW'({e_r, 8'h00});
        div_dv    = DIV_DW'(sq_root);
        state_nxt = ST_WAITP;
      end
      ST_WAITP: begin
        if (!div_busy) begin
          state_nxt = ST_BETA;
        end
      end
      ST_BETA: state_nxt = ST_CHKB;
      ST_CHKB: state_nxt = (wp_r[61:8] == '0) ? ST_NEXT : ST_RD_MEAN;
      ST_RD_MEAN: begin
        rd_slot   = SLOT_W'(SLOT_OMEAN) + SLOT_W'(j_r);
        state_nxt = ST_RD_COV;
      end
      ST_RD_COV: begin
        rd_slot   = SLOT_W'(SLOT_COV) + SLOT_W'(j_r);
        state_nxt = ST_CAP_COV;
      end
      ST_CAP_COV: state_nxt = ST_MULC;
      ST_MULC:    state_nxt = ST_DIVC;
      ST_DIVC: begin
        div_start = 1'b1;
        div_dd    = DIV_NW'(cprod_r);
        div_dv    = DIV_DW'(var_r);
        state_nxt = ST_WAITC;
      end
      ST_WAITC: begin
        if (!div_busy) begin
          state_nxt = ST_MSUM;
        end
      end
      ST_MSUM:   state_nxt = ST_ACC_LO;
      ST_ACC_LO: state_nxt = ST_ACC_HI;
      ST_ACC_HI: state_nxt = ST_ACC_ADD;
      ST_ACC_ADD: begin
        state_nxt = (32'(j_r) == SHOWN_DIMS - 1) ? ST_NEXT : ST_RD_MEAN;
      end
      ST_NEXT: state_nxt = (k_inc == n_r) ? ST_FIN : ST_FETCH_W;
      ST_FIN:  state_nxt = (den_r == '0) ? ST_DONE : ST_FIN_DIV;
      ST_FIN_DIV: begin
        div_start = 1'b1;
        div_dd    = DIV_NW'(accmag);
        div_dv    = DIV_DW'(den_r);
        state_nxt = ST_FIN_WAIT;
      end
      ST_FIN_WAIT: begin
        if (!div_busy) begin
          state_nxt = ST_FIN_SAT;
        end
      end
      ST_FIN_SAT: begin
        state_nxt = (32'(j_r) == SHOWN_DIMS - 1) ? ST_DONE : ST_FIN_DIV;
      end
      ST_DONE: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      act_r       <= 4'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        act_r <= cfg_data;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers, each loaded in the step that computes it.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (q_accept) begin
          t_r   <= in_data.query_time;
          n_r   <= n_new;
          k_r   <= '0;
          den_r <= '0;
          for (int i = 0; i < SHOWN_DIMS; i++) begin
            acc_r[i] <= '0;
          end
        end
      end
      ST_FETCH_MU:  w_r   <= rd_data;
      ST_FETCH_VAR: mu_r  <= rd_data;
      ST_CAP_VAR:   var_r <= rd_data;
      ST_PREP: begin
        d_neg_r <= d_full[32];
        ad_r    <= d_full[32] ? (33'd0 - d_full) : d_full;
      end
      ST_SQUARE: begin
        prod_r  <= 66'(ad_r) * 66'(ad_r);
        sq_in_r <= SQ_IN_W'(TWO_PI_Q16) * SQ_IN_W'(var_r[30:0]);
      end
      ST_LOG: begin
        y_r   <= 38'(div_quo[21:1]) * 38'(LOG2E_Q16);
        b_r   <= 4'd15;
        one_r <= 1'b1;
        r_r   <= '0;
      end
      ST_EXP: begin
        // Multiply in one table factor for each set fraction bit.
        if (frac[b_r]) begin
          if (one_r) begin
            r_r <= POW_TAB[b_r];
          end else begin
            r_r <= rmul[63:32];
          end
          one_r <= 1'b0;
        end
        b_r <= b_r - 4'd1;
      end
      ST_SHIFT: e_r  <= {one_r, r_r} >> y_r[37:32];
      ST_BETA:  wp_r <= 62'(w_r[30:0]) * 62'(div_quo[30:0]);
      ST_CHKB: begin
        beta_r <= wp_r[61:8];
        den_r  <= den_r + 57'(wp_r[61:8]);
        j_r    <= '0;
      end
      ST_RD_COV:  mean_r <= rd_data;
      ST_CAP_COV: cov_r  <= rd_data;
      ST_MULC: begin
        cprod_r <= 65'(acov) * 65'(ad_r);
        mneg_r  <= cov_r[31] ^ d_neg_r;
      end
      ST_MSUM: begin
        // Conditional mean, saturated to 32 bits.
        if (msum > 36'sh0_7FFF_FFFF) begin
          m_r <= 32'h7FFF_FFFF;
        end else if (msum < 36'shF_8000_0000) begin
          m_r <= 32'h8000_0000;
        end else begin
          m_r <= msum[31:0];
        end
      end
      ST_ACC_LO: plo_r <= 59'(beta_r[26:0]) * 59'(mmag);
      ST_ACC_HI: phi_r <= 59'(beta_r[53:27]) * 59'(mmag);
      ST_ACC_ADD: begin
        acc_r[j_r] <= acc_r[j_r] + (m_r[31] ? (90'd0 - term) : term);
        j_r        <= j_r + DIM_W'(1);
      end
      ST_NEXT: k_r <= k_inc;
      ST_FIN: begin
        j_r <= '0;
        for (int i = 0; i < RES_N; i++) begin
          res_r[i] <= '0;
        end
      end
      ST_FIN_SAT: begin
        res_r[j_r] <= qsat;
        j_r        <= j_r + DIM_W'(1);
      end
      ST_DONE: begin
        if (load_out) begin
          out_data_r.time_echo  <= t_r;
          out_data_r.out_x      <= res_r[0];
          out_data_r.out_y      <= res_r[1];
          out_data_r.out_z      <= res_r[2];
          out_data_r.no_support <= (den_r == '0);
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_sqrt_free: assert property (@(posedge clk) disable iff (!rst_n)
    sq_start |-> !sq_busy)
    else $error("square-root unit started while busy");

  a_load_single: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_data.mode == MODE_LOAD) |=> !in_stall)
    else $error("load item held the input channel");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_accept |=> (in_stall && !out_valid) || (in_stall && out_valid))
    else $error("query item did not occupy the sequencer");
`endif

endmodule

`default_nettype wire

### src/gmr_ram.sv
`default_nettype none

module gmr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### src/gmr_div.sv
`default_nettype none

module gmr_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [gmr_pkg::DIV_NW-1:0] dividend,
  input  wire logic [gmr_pkg::DIV_DW-1:0] divisor,
  output logic                           busy,
  output logic [gmr_pkg::DIV_NW-1:0]     quotient
);

  import gmr_pkg::*;

  logic                 busy_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_NW-1:0]    quo_r;
  logic [DIV_DW-1:0]    rem_r;
  logic [DIV_DW-1:0]    dv_r;
  logic [DIV_DW:0]      rem_sh;
  logic                 ge;

  // One restoring step: shift in the next dividend bit and try the divisor.
  assign rem_sh = {rem_r, quo_r[DIV_NW-1]};
  assign ge     = (rem_sh >= {1'b0, dv_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == '0) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dv_r  <= divisor;
      cnt_r <= DIV_CNT_W'(DIV_NW - 1);
    end else if (busy_r) begin
      rem_r <= ge ? DIV_DW'(rem_sh - {1'b0, dv_r}) : rem_sh[DIV_DW-1:0];
      quo_r <= {quo_r[DIV_NW-2:0], ge};
      cnt_r <= cnt_r - DIV_CNT_W'(1);
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

### src/gmr_isqrt.sv
`default_nettype none

module gmr_isqrt (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [gmr_pkg::SQ_IN_W-1:0]  radicand,
  output logic                             busy,
  output logic [gmr_pkg::SQ_OUT_W-1:0]     root
);

  import gmr_pkg::*;

  logic                busy_r;
  logic [SQ_CNT_W-1:0] cnt_r;
  logic [SQ_IN_W-1:0]  x_r;
  logic [SQ_OUT_W:0]   rem_r;
  logic [SQ_OUT_W-1:0] root_r;
  logic [SQ_OUT_W+2:0] rem_t;
  logic [SQ_OUT_W+2:0] trial;
  logic                ge;

  // One root bit per cycle from the next two radicand bits.
  assign rem_t = {rem_r, x_r[SQ_IN_W-1:SQ_IN_W-2]};
  assign trial = {1'b0, root_r, 2'b01};
  assign ge    = (rem_t >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == '0) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= SQ_CNT_W'(SQ_OUT_W - 1);
    end else if (busy_r) begin
      rem_r  <= ge ? (SQ_OUT_W + 1)'(rem_t - trial) : rem_t[SQ_OUT_W:0];
      root_r <= {root_r[SQ_OUT_W-2:0], ge};
      x_r    <= {x_r[SQ_IN_W-3:0], 2'b00};
      cnt_r  <= cnt_r - SQ_CNT_W'(1);
    end
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

`default_nettype wire
